// ===== design/sle_pkg.sv =====
// Package for the sequential list engine: sizes, codes, payload structs and the
// controller/datapath command and status structs. It has no dependencies.
package sle_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int POS_W     = 4;
    localparam int CNT_OUT_W = 5;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request kinds
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [POS_W-1:0]     position;
        logic [CNT_OUT_W-1:0] count;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RK_INSERT,
        RK_FULL,
        RK_FOUND,
        RK_REMOVED,
        RK_MISS
    } res_kind_t;

    typedef struct packed {
        logic      accept;
        logic      scan_en;
        logic      hit_load;
        logic      shift_en;
        logic      res_load;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ins_ok;
        logic hit;
        logic exhausted;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== design/sequential_list_engine_unit.sv =====
// Sequential list engine: an ordered list of signed 32-bit values.
// Input channel s_valid/s_ready/s_data carries one request (op, value):
//   insert appends at the current count unless the list is full, search
//   reports the lowest filled position holding the value, delete removes
//   that entry and moves every later entry down one place.
// Result channel m_valid/m_ready/m_data carries one result per request:
//   status, position and the count after the request.
// cfg_wr_en/cfg_wr_data write the capacity register (reset 16; a value above
//   the store depth acts as the depth); write it only while the block is idle.
// Timing: one request at a time. Insert or an unused op code goes straight to
//   the done state. Search and delete walk the store one entry per cycle
//   through its single read port; search stops at the first match or after
//   the last filled entry, and delete then moves the later entries down. The
//   next request can be accepted in the cycle after the result loads.
// The result sits in an output register; a new request is accepted while
//   it waits, but the next result is held back until the receiver takes it.
// Reset clears the count, the pipeline and the result valid; the entry
//   store is not cleared, since only filled entries are ever read.
module sequential_list_engine_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [4:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  sle_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sle_pkg::out_item_t  m_data
);
    import sle_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    sle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (s_data.op),
        .stat    (stat),
        .cmd     (cmd)
    );

    sle_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== design/sle_ctrl.sv =====
// Controller state machine of the sequential list engine.
// Depends on sle_pkg for the state, command and status types.
module sle_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         op,
    input  sle_pkg::dp_status_t stat,
    output sle_pkg::ctrl_cmd_t  cmd
);
    import sle_pkg::*;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;
    logic      is_del_reg, is_del_next;
    logic      accept;

    assign accept = s_valid && (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            kind_reg   <= RK_MISS;
            is_del_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            is_del_reg <= is_del_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        is_del_next = is_del_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_INSERT: begin
                            kind_next  = stat.ins_ok ? RK_INSERT : RK_FULL;
                            state_next = S_DONE;
                        end
                        OP_SEARCH: begin
                            is_del_next = 1'b0;
                            state_next  = S_SCAN;
                        end
                        OP_DELETE: begin
                            is_del_next = 1'b1;
                            state_next  = S_SCAN;
                        end
                        default: begin
                            kind_next  = RK_MISS;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (stat.hit) begin
                    if (is_del_reg) begin
                        state_next = S_SHIFT;
                    end else begin
                        kind_next  = RK_FOUND;
                        state_next = S_DONE;
                    end
                end else if (stat.exhausted) begin
                    kind_next  = RK_MISS;
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                if (stat.exhausted) begin
                    kind_next  = RK_REMOVED;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == S_IDLE);
        cmd.accept   = accept;
        cmd.scan_en  = (state_reg == S_SCAN) && !stat.hit;
        cmd.hit_load = (state_reg == S_SCAN) && stat.hit;
        cmd.shift_en = (state_reg == S_SHIFT);
        cmd.res_load = (state_reg == S_DONE) && !stat.out_busy;
        cmd.res_kind = kind_reg;
    end

endmodule

// ===== design/sle_datapath.sv =====
// Datapath of the sequential list engine: entry store, scan pointer, count,
// capacity register and result register. Depends on sle_pkg.
module sle_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [4:0]            cfg_wr_data,
    input  sle_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sle_pkg::out_item_t    m_data,
    input  sle_pkg::ctrl_cmd_t    cmd,
    output sle_pkg::dp_status_t   stat
);
    import sle_pkg::*;

    logic signed [31:0] mem [DEPTH];

    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [31:0] value_reg;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic signed [31:0] rd_data_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic               issue;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic signed [31:0] mem_wd;

    assign issue = (cmd.scan_en || cmd.shift_en) && (ptr_reg < count_reg);

    assign stat.ins_ok    = (CMP_W'(count_reg) < CMP_W'(cap_reg)) &&
                            (count_reg < CNT_W'(DEPTH));
    assign stat.hit       = rd_vld_reg && (rd_data_reg == value_reg);
    assign stat.exhausted = !rd_vld_reg && (ptr_reg >= count_reg);
    assign stat.out_busy  = m_valid_reg && !m_ready;

    // shift moves the entry just read down one place; insert appends at count
    always_comb begin
        if (cmd.shift_en) begin
            mem_we = rd_vld_reg;
            mem_wa = rd_idx_reg - IDX_W'(1);
            mem_wd = rd_data_reg;
        end else begin
            mem_we = cmd.res_load && (cmd.res_kind == RK_INSERT);
            mem_wa = count_reg[IDX_W-1:0];
            mem_wd = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.accept) begin
            ptr_next = '0;
        end else if (cmd.hit_load) begin
            ptr_next = CNT_W'(rd_idx_reg) + CNT_W'(1);
        end else if (issue) begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_comb begin
        count_next  = count_reg;
        m_data_next = m_data_reg;
        if (cmd.res_load) begin
            m_data_next.position = '0;
            case (cmd.res_kind)
                RK_INSERT: begin
                    count_next           = count_reg + CNT_W'(1);
                    m_data_next.status   = STAT_OK;
                    m_data_next.position = POS_W'(count_reg);
                end
                RK_FULL: begin
                    m_data_next.status = STAT_FULL;
                end
                RK_FOUND: begin
                    m_data_next.status   = STAT_OK;
                    m_data_next.position = POS_W'(hit_idx_reg);
                end
                RK_REMOVED: begin
                    count_next           = count_reg - CNT_W'(1);
                    m_data_next.status   = STAT_OK;
                    m_data_next.position = POS_W'(hit_idx_reg);
                end
                default: begin
                    m_data_next.status = STAT_NOT_FOUND;
                end
            endcase
            m_data_next.count = CNT_OUT_W'(count_next);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= issue;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            value_reg <= s_data.value;
        end
        if (issue) begin
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.hit_load) begin
            hit_idx_reg <= rd_idx_reg;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above store depth");

    a_shift_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_en && rd_vld_reg) |-> (rd_idx_reg != '0))
        else $error("shift write below position zero");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> !(m_valid_reg && !m_ready))
        else $error("result loaded over a pending transaction");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hit_load |-> (CNT_W'(rd_idx_reg) < count_reg))
        else $error("match reported beyond filled entries");

    a_remove_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.res_load && cmd.res_kind == RK_REMOVED) |-> (count_reg != '0))
        else $error("remove from an empty list");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the sequential list engine: a directed table, then random phases at
// varied capacities, results checked against typed table rows or an in-bench predictor.
// Depends on sle_pkg and sequential_list_engine_unit.
module tb_top;
    import sle_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         ITEM_GOAL  = 1800;
    localparam int         IDLE_LIMIT = 4000;
    localparam int         MAX_REPORT = 10;

    typedef struct packed {
        logic       set_cap;
        logic [4:0] cap;
        logic [1:0] op;
        logic [31:0] value;
        logic       typed;
        out_item_t  res;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    // predictor state
    logic [31:0] list_mem [DEPTH];
    int unsigned list_fill;
    logic [4:0]  list_cap;

    out_item_t pending_results [$];
    int        mismatch_cnt;
    int        idle_cycles;
    int        sent_cnt;
    int        ready_hold;
    bit        quiet_phase;

    stim_row_t dir_tab [22] = '{
        '{1'b0, 5'd0,  OP_SEARCH, 32'h0000_0000, 1'b1, '{STAT_NOT_FOUND, 4'd0, 5'd0}},
        '{1'b0, 5'd0,  OP_DELETE, 32'h0000_0000, 1'b1, '{STAT_NOT_FOUND, 4'd0, 5'd0}},
        '{1'b0, 5'd0,  OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{STAT_NOT_FOUND, 4'd0, 5'd0}},
        '{1'b0, 5'd0,  OP_INSERT, 32'h8000_0000, 1'b1, '{STAT_OK,        4'd0, 5'd1}},
        '{1'b0, 5'd0,  OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{STAT_OK,        4'd1, 5'd2}},
        '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 5'd0,  OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 5'd0,  OP_SEARCH, 32'h7FFF_FFFF, 1'b1, '{STAT_OK,        4'd1, 5'd5}},
        '{1'b0, 5'd0,  OP_SEARCH, 32'h0000_0005, 1'b1, '{STAT_NOT_FOUND, 4'd0, 5'd5}},
        '{1'b0, 5'd0,  OP_DELETE, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  OP_SEARCH, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 5'd0,  OP_DELETE, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 5'd0,  OP_DELETE, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 5'd0,  OP_UNUSED, 32'h5555_5555, 1'b1, '{STAT_NOT_FOUND, 4'd0, 5'd2}},
        // capacity dropped below the count: inserts bounce while the count is not below it
        '{1'b1, 5'd1,  OP_INSERT, 32'h0000_0007, 1'b1, '{STAT_FULL,      4'd0, 5'd2}},
        '{1'b0, 5'd0,  OP_DELETE, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0007, 1'b1, '{STAT_FULL,      4'd0, 5'd1}},
        '{1'b1, 5'd0,  OP_DELETE, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0005, 1'b1, '{STAT_FULL,      4'd0, 5'd0}},
        '{1'b1, 5'd31, OP_INSERT, 32'hAAAA_AAAA, 1'b1, '{STAT_OK,        4'd0, 5'd1}},
        '{1'b1, 5'd16, OP_SEARCH, 32'hAAAA_AAAA, 1'b0, '0}
    };

    sequential_list_engine_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #2 aclk = ~aclk;

    // Apply one request to the list copy and return the result it should give.
    function automatic out_item_t apply_list_op(logic [1:0] op, logic [31:0] v);
        out_item_t   r;
        int unsigned lim;
        int          hit;
        int unsigned pos;
        lim = (list_cap < DEPTH) ? list_cap : DEPTH;
        hit = -1;
        pos = 0;
        r.status = STAT_NOT_FOUND;
        if (op == OP_SEARCH || op == OP_DELETE) begin
            for (int i = 0; i < list_fill && i < DEPTH; i++) begin
                if (hit < 0 && list_mem[i] == v) begin
                    hit = i;
                end
            end
        end
        case (op)
            OP_INSERT: begin
                if (list_fill < lim) begin
                    list_mem[list_fill] = v;
                    pos = list_fill;
                    list_fill++;
                    r.status = STAT_OK;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            OP_SEARCH: begin
                if (hit >= 0) begin
                    pos = hit;
                    r.status = STAT_OK;
                end
            end
            OP_DELETE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < list_fill && i + 1 < DEPTH; i++) begin
                        list_mem[i] = list_mem[i + 1];
                    end
                    list_fill--;
                    pos = hit;
                    r.status = STAT_OK;
                end
            end
            default: begin
            end
        endcase
        r.position = POS_W'(pos);
        r.count    = CNT_OUT_W'(list_fill);
        return r;
    endfunction

    // Mostly back-to-back (always in a quiet phase), sometimes a short pause, rarely a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Present one transaction; called and returns at a falling edge.
    task automatic send_request(logic [1:0] op, logic [31:0] v, logic typed, out_item_t res);
        int        gap;
        out_item_t pred;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        pred = apply_list_op(op, v);
        pending_results.push_back(typed ? res : pred);
        s_valid      <= 1'b1;
        s_data.op    <= op;
        s_data.value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt++;
        @(negedge aclk);
    endtask

    // Drain every outstanding result, let the block settle, then write capacity.
    task automatic write_capacity(logic [4:0] cap);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        list_cap = cap;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
            ready_hold = idle_len();
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORT) begin
                    $display("unexpected result: status %0d pos %0d count %0d",
                             m_data.status, m_data.position, m_data.count);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status || m_data.position !== want.position
                        || m_data.count !== want.count) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORT) begin
                        $display("mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                                 want.status, want.position, want.count,
                                 m_data.status, m_data.position, m_data.count);
                    end
                end
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [31:0] pool [6];
        logic [1:0]  op;
        logic [31:0] v;
        logic [4:0]  cap;
        int          ins_w;
        int          del_w;
        int          len;
        int          r;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        mismatch_cnt = 0;
        idle_cycles  = 0;
        sent_cnt     = 0;
        ready_hold   = 0;
        quiet_phase  = 1'b0;
        list_fill    = 0;
        list_cap     = CAP_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            list_mem[i] = '0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].set_cap) begin
                write_capacity(dir_tab[i].cap);
            end
            send_request(dir_tab[i].op, dir_tab[i].value, dir_tab[i].typed, dir_tab[i].res);
        end

        // random phases: each picks a capacity, an op mix and a small value pool
        while (sent_cnt < ITEM_GOAL) begin
            r = $urandom_range(0, 9);
            case (r)
                0:       cap = 5'd0;
                1:       cap = 5'd1;
                2:       cap = 5'd16;
                3:       cap = 5'($urandom_range(17, 31));
                4:       cap = 5'd31;
                default: cap = 5'($urandom_range(2, 15));
            endcase
            write_capacity(cap);
            quiet_phase = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) == 0) begin
                ins_w = 60;
                del_w = 20;
            end else begin
                ins_w = 35;
                del_w = 45;
            end
            foreach (pool[i]) begin
                r = $urandom_range(0, 5);
                pool[i] = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF : $urandom;
            end
            len = $urandom_range(40, 160);
            for (int n = 0; n < len; n++) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    op = OP_UNUSED;
                end else if (r < 5 + ins_w) begin
                    op = OP_INSERT;
                end else if (r < 5 + ins_w + del_w) begin
                    op = OP_DELETE;
                end else begin
                    op = OP_SEARCH;
                end
                v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)] : $urandom;
                send_request(op, v, 1'b0, '0);
            end
        end
        quiet_phase = 1'b0;

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // hold a while longer so a stray extra result is caught
        repeat (50) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
